/* hdl/pida_pkg.sv */
// shared types, constants and helpers for the positional insert/delete list
// depends on nothing; every other file refers to it by scoped names
package pida_pkg;

	// list geometry
	localparam int DEPTH = 64;
	localparam int WIDTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 7;
	localparam int VAL_W = 32;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// read-back reduction: groups of cells or-ed together, then the groups
	localparam int GRP  = 8;
	localparam int NGRP = (DEPTH + GRP - 1) / GRP;

	// request codes
	localparam logic [1:0] REQ_INS = 2'd0;
	localparam logic [1:0] REQ_DEL = 2'd1;
	localparam logic [1:0] REQ_RD  = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef logic [WIDTH-1:0] entry_t;

	// what every cell does in the update cycle
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INS,
		CMD_DEL,
		CMD_RD
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t            op;
		logic [CMP_W-1:0]   pos;
		entry_t             val;
	} cell_cmd_t;

	// port value to stored entry: keep low WIDTH bits, zero-extend if wider
	function automatic entry_t to_entry(input logic [VAL_W-1:0] v);
		logic [WIDTH+VAL_W-1:0] tmp;
		tmp = {{WIDTH{1'b0}}, v};
		return tmp[WIDTH-1:0];
	endfunction

	// stored entry to port value: low 32 bits, zero-extend if narrower
	function automatic logic [VAL_W-1:0] from_entry(input entry_t e);
		logic [WIDTH+VAL_W-1:0] tmp;
		tmp = {{VAL_W{1'b0}}, e};
		return tmp[VAL_W-1:0];
	endfunction

endpackage

/* hdl/positional_insert_delete_array.sv */
// positional insert/delete list over a chain of storage cells
// a taken request passes the request register, the second-stage registers and the result
// register before its result strobe; busy covers decode/shift and read-back of the reduction,
// so no new request is taken before the last is through; the cell shift is one register update
// reset: count cleared to zero, no request in flight; entries are not cleared
// the receiver cannot stall: done is high for exactly one cycle per request
// depends on pida_pkg and pida_cell
module positional_insert_delete_array (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          req_type,
	input  logic [pida_pkg::POS_W-1:0]          position,
	input  logic signed [pida_pkg::VAL_W-1:0]   new_value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic signed [pida_pkg::VAL_W-1:0]   read_value,
	output logic [pida_pkg::POS_W-1:0]          count_now
);

	logic                               vld_s1;
	logic [1:0]                         req_s1;
	logic [pida_pkg::POS_W-1:0]         pos_s1;
	pida_pkg::entry_t                   val_s1;

	logic                               vld_s2;
	logic [1:0]                         st_s2;
	logic [pida_pkg::CNT_W-1:0]         cnt_s2;
	pida_pkg::entry_t                   grp_s2 [pida_pkg::NGRP];

	logic [pida_pkg::CNT_W-1:0]         count_q;
	logic                               done_q;
	logic [1:0]                         status_q;
	logic [pida_pkg::VAL_W-1:0]         read_value_q;
	logic [pida_pkg::CNT_W-1:0]         count_now_q;

	pida_pkg::cell_cmd_t                cmd;
	logic [1:0]                         st_d;
	logic [pida_pkg::CNT_W-1:0]         cnt_d;
	logic [pida_pkg::CMP_W-1:0]         pos_x;
	logic [pida_pkg::CMP_W-1:0]         cnt_x;

	pida_pkg::entry_t                   cell_val [pida_pkg::DEPTH];
	pida_pkg::entry_t                   cell_rd  [pida_pkg::DEPTH];
	pida_pkg::entry_t                   grp_d    [pida_pkg::NGRP];
	pida_pkg::entry_t                   rd_all;

	assign busy = vld_s1 | vld_s2;

	// request register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req_type;
			pos_s1 <= position;
			val_s1 <= pida_pkg::to_entry(new_value);
		end
	end

	// range checks and cell command
	assign pos_x = pida_pkg::CMP_W'(pos_s1);
	assign cnt_x = pida_pkg::CMP_W'(count_q);

	always_comb begin
		st_d    = pida_pkg::ST_BADPOS;
		cnt_d   = count_q;
		cmd.op  = pida_pkg::CMD_HOLD;
		cmd.pos = pos_x;
		cmd.val = val_s1;
		case (req_s1)
			pida_pkg::REQ_INS: begin
				if (pos_x > cnt_x) begin
					st_d = pida_pkg::ST_BADPOS;
				end else if (count_q == pida_pkg::CNT_W'(pida_pkg::DEPTH)) begin
					st_d = pida_pkg::ST_FULL;
				end else begin
					st_d   = pida_pkg::ST_OK;
					cnt_d  = count_q + 1'b1;
					cmd.op = pida_pkg::CMD_INS;
				end
			end
			pida_pkg::REQ_DEL: begin
				if (pos_x < cnt_x) begin
					st_d   = pida_pkg::ST_OK;
					cnt_d  = count_q - 1'b1;
					cmd.op = pida_pkg::CMD_DEL;
				end
			end
			pida_pkg::REQ_RD: begin
				if (pos_x < cnt_x) begin
					st_d   = pida_pkg::ST_OK;
					cmd.op = pida_pkg::CMD_RD;
				end
			end
			default: begin
				st_d = pida_pkg::ST_BADPOS;
			end
		endcase
		if (!vld_s1) begin
			cmd.op = pida_pkg::CMD_HOLD;
			cnt_d  = count_q;
		end
	end

	// chain of cells
	for (genvar i = 0; i < pida_pkg::DEPTH; i++) begin : g_cell
		pida_pkg::entry_t left_w;
		pida_pkg::entry_t right_w;
		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_val[i-1];
		end
		if (i == pida_pkg::DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = cell_val[i+1];
		end
		pida_cell u_cell (
			.clk   (clk),
			.idx   (pida_pkg::IDX_W'(i)),
			.cmd   (cmd),
			.left  (left_w),
			.right (right_w),
			.value (cell_val[i]),
			.rd    (cell_rd[i])
		);
	end

	// first level of the read-back or tree
	always_comb begin
		for (int g = 0; g < pida_pkg::NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < pida_pkg::GRP; k++) begin
				if (g * pida_pkg::GRP + k < pida_pkg::DEPTH) begin
					grp_d[g] = grp_d[g] | cell_rd[g * pida_pkg::GRP + k];
				end
			end
		end
	end

	// count and second-stage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			vld_s2  <= 1'b0;
		end else begin
			count_q <= cnt_d;
			vld_s2  <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			st_s2  <= st_d;
			cnt_s2 <= cnt_d;
			grp_s2 <= grp_d;
		end
	end

	// second level of the or tree
	always_comb begin
		rd_all = '0;
		for (int g = 0; g < pida_pkg::NGRP; g++) begin
			rd_all = rd_all | grp_s2[g];
		end
	end

	// result beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			status_q     <= st_s2;
			read_value_q <= pida_pkg::from_entry(rd_all);
			count_now_q  <= cnt_s2;
		end
	end

	assign done       = done_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign count_now  = pida_pkg::POS_W'(count_now_q);

endmodule

/* hdl/pida_cell.sv */
// one storage cell of the list: holds an entry and trades it with its neighbors
// depends on pida_pkg
module pida_cell (
	input  logic                        clk,
	input  logic [pida_pkg::IDX_W-1:0]  idx,
	input  pida_pkg::cell_cmd_t         cmd,
	input  pida_pkg::entry_t            left,
	input  pida_pkg::entry_t            right,
	output pida_pkg::entry_t            value,
	output pida_pkg::entry_t            rd
);

	logic [pida_pkg::CMP_W-1:0] idx_x;
	logic                       at_pos;
	logic                       past_pos;
	pida_pkg::entry_t           value_q;

	// place of this cell against the requested position
	assign idx_x    = pida_pkg::CMP_W'(idx);
	assign at_pos   = (idx_x == cmd.pos);
	assign past_pos = (idx_x > cmd.pos);

	// shift up on insert, shift down on delete, else keep
	always_ff @(posedge clk) begin
		case (cmd.op)
			pida_pkg::CMD_INS: begin
				if (at_pos) begin
					value_q <= cmd.val;
				end else if (past_pos) begin
					value_q <= left;
				end
			end
			pida_pkg::CMD_DEL: begin
				if (at_pos || past_pos) begin
					value_q <= right;
				end
			end
			default: begin
				value_q <= value_q;
			end
		endcase
	end

	assign value = value_q;

	// read contribution, zero unless this cell is the one read
	assign rd = (cmd.op == pida_pkg::CMD_RD && at_pos) ? value_q : '0;

endmodule

/* hdl/pida_checker.sv */
// port-level checks for the positional insert/delete list, bound to the top
// depends on pida_pkg and positional_insert_delete_array
module pida_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic                                busy,
	input  logic                                done,
	input  logic [1:0]                          status,
	input  logic signed [pida_pkg::VAL_W-1:0]   read_value,
	input  logic [pida_pkg::POS_W-1:0]          count_now
);

	// each taken request is followed by its result beat
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##3 done)
		else $error("result beat missing after request");

	// a taken request holds the block busy
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after request");

	// failed requests return no data
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == pida_pkg::ST_BADPOS || status == pida_pkg::ST_FULL)
		|-> read_value == '0)
		else $error("nonzero read data on failed request");

	// full is only reported with the list at capacity
	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == pida_pkg::ST_FULL
		|-> count_now == pida_pkg::POS_W'(pida_pkg::DEPTH))
		else $error("full status with list below capacity");

	// status never carries the unused code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == pida_pkg::ST_OK || status == pida_pkg::ST_BADPOS
		|| status == pida_pkg::ST_FULL))
		else $error("unused status code");

endmodule

bind positional_insert_delete_array pida_checker u_pida_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.read_value (read_value),
	.count_now  (count_now)
);

/* bench/tb_positional_insert_delete_array.sv */
// self-checking bench for positional_insert_delete_array: insert, delete and read beats
// against a shadow list, directed corner cases then three random phases of sender gaps
// depends on pida_pkg and the rtl of positional_insert_delete_array
module tb_positional_insert_delete_array;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 8;

	// request code the block does not define
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		logic [1:0]                         kind;
		logic [pida_pkg::POS_W-1:0]         pos;
		logic signed [pida_pkg::VAL_W-1:0]  val;
	} list_req_t;

	typedef struct {
		logic [1:0]                         st;
		logic signed [pida_pkg::VAL_W-1:0]  rd;
		logic [pida_pkg::POS_W-1:0]         cnt;
	} list_resp_t;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                start = 1'b0;
	logic                                busy;
	logic [1:0]                          req_type = pida_pkg::REQ_INS;
	logic [pida_pkg::POS_W-1:0]          position = '0;
	logic signed [pida_pkg::VAL_W-1:0]   new_value = '0;
	logic                                done;
	logic [1:0]                          status;
	logic signed [pida_pkg::VAL_W-1:0]   read_value;
	logic [pida_pkg::POS_W-1:0]          count_now;

	// shadow of the list contents
	pida_pkg::entry_t            shadow_list [pida_pkg::DEPTH];
	int                          shadow_len = 0;

	list_req_t                   pending_q [$];
	list_resp_t                  expected_q [$];
	list_resp_t                  want;
	list_req_t                   got_req;
	logic                        beat_taken = 1'b0;
	int                          gap_pct = 15;
	int                          gen_len = 0;
	int                          cycle_count = 0;
	int                          fail_count = 0;
	int                          n_ok = 0;
	int                          n_badpos = 0;
	int                          n_full = 0;
	int                          n_reads = 0;
	int                          deepest = 0;

	positional_insert_delete_array dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req_type   (req_type),
		.position   (position),
		.new_value  (new_value),
		.done       (done),
		.status     (status),
		.read_value (read_value),
		.count_now  (count_now)
	);

	always #10 clk = ~clk;

	// apply one request to the shadow list and return what the block should answer
	function automatic list_resp_t list_update(input list_req_t r);
		list_resp_t o;
		int len;
		int i;
		o.st = pida_pkg::ST_BADPOS;
		o.rd = '0;
		len = shadow_len;
		case (r.kind)
			pida_pkg::REQ_INS: begin
				if (r.pos > len)
					o.st = pida_pkg::ST_BADPOS;
				else if (len >= pida_pkg::DEPTH)
					o.st = pida_pkg::ST_FULL;
				else begin
					for (i = len; i > r.pos; i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[r.pos] = pida_pkg::entry_t'(r.val);
					len++;
					o.st = pida_pkg::ST_OK;
				end
			end
			pida_pkg::REQ_DEL: begin
				if (r.pos < len) begin
					for (i = r.pos; i + 1 < len; i++)
						shadow_list[i] = shadow_list[i+1];
					len--;
					o.st = pida_pkg::ST_OK;
				end
			end
			pida_pkg::REQ_RD: begin
				if (r.pos < len) begin
					o.rd = pida_pkg::VAL_W'(shadow_list[r.pos]);
					o.st = pida_pkg::ST_OK;
				end
			end
			default: begin
			end
		endcase
		shadow_len = len;
		o.cnt = pida_pkg::POS_W'(len);
		return o;
	endfunction

	// queue one request, tracking the length it leaves so later positions can aim
	function automatic void add_req(input logic [1:0] kind, input int pos,
			input logic [pida_pkg::VAL_W-1:0] val);
		list_req_t r;
		r.kind = kind;
		r.pos = pida_pkg::POS_W'(pos);
		r.val = val;
		pending_q.push_back(r);
		if (kind == pida_pkg::REQ_INS && pos <= gen_len && gen_len < pida_pkg::DEPTH)
			gen_len++;
		else if (kind == pida_pkg::REQ_DEL && pos < gen_len)
			gen_len--;
	endfunction

	// random beats in segments that grow, shrink or churn the list
	task automatic add_random(input int n_items, input int first_grow_pct);
		int left;
		int grow_pct;
		int roll;
		int pos;
		logic [1:0] kind;
		logic [pida_pkg::VAL_W-1:0] val;
		left = 0;
		grow_pct = first_grow_pct;
		for (int k = 0; k < n_items; k++) begin
			if (left == 0) begin
				left = $urandom_range(30, 120);
				if (k != 0)
					case ($urandom_range(0, 2))
						0: grow_pct = 80;
						1: grow_pct = 25;
						default: grow_pct = 50;
					endcase
			end
			left--;
			roll = $urandom_range(0, 99);
			if (roll < 3)
				kind = REQ_UNUSED;
			else if (roll < grow_pct)
				kind = pida_pkg::REQ_INS;
			else if ($urandom_range(0, 2) == 2)
				kind = pida_pkg::REQ_RD;
			else
				kind = pida_pkg::REQ_DEL;
			roll = $urandom_range(0, 99);
			if (roll < 8)
				pos = $urandom_range(0, 127);
			else if (roll < 16) begin
				// edges: the end of the list and one past it
				if (kind == pida_pkg::REQ_INS)
					pos = gen_len + $urandom_range(0, 1);
				else
					pos = (gen_len == 0) ? 0 : gen_len - $urandom_range(0, 1);
			end else if (kind == pida_pkg::REQ_INS)
				pos = $urandom_range(0, gen_len);
			else
				pos = (gen_len == 0) ? 0 : $urandom_range(0, gen_len - 1);
			case ($urandom_range(0, 19))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = 32'h0000_0000;
				3: val = 32'hffff_ffff;
				default: val = $urandom;
			endcase
			add_req(kind, pos, val);
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || start)
			@(posedge clk);
	endtask

	// driver: present the next beat at the falling edge, hold it until taken
	always @(negedge clk) begin
		if (!arst_n)
			start <= 1'b0;
		else if (start && !beat_taken) begin
		end else if (pending_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
			req_type <= pending_q[0].kind;
			position <= pending_q[0].pos;
			new_value <= pending_q[0].val;
			start <= 1'b1;
			void'(pending_q.pop_front());
		end else
			start <= 1'b0;
	end

	// monitor: check result beats, then predict the beat taken at this edge
	always @(posedge clk) begin
		cycle_count++;
		if (arst_n) begin
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result beat with no request outstanding");
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						fail_count++;
					end
					if (read_value !== want.rd) begin
						$error("read_value: expected %0d, got %0d", want.rd, read_value);
						fail_count++;
					end
					if (count_now !== want.cnt) begin
						$error("count_now: expected %0d, got %0d", want.cnt, count_now);
						fail_count++;
					end
				end
			end
			beat_taken <= start && !busy;
			if (start && !busy) begin
				got_req.kind = req_type;
				got_req.pos = position;
				got_req.val = new_value;
				want = list_update(got_req);
				expected_q.push_back(want);
				case (want.st)
					pida_pkg::ST_OK: n_ok++;
					pida_pkg::ST_FULL: n_full++;
					default: n_badpos++;
				endcase
				if (req_type == pida_pkg::REQ_RD && want.st == pida_pkg::ST_OK)
					n_reads++;
				if (shadow_len > deepest)
					deepest = shadow_len;
			end
		end else
			beat_taken <= 1'b0;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("FAIL");
			$finish;
		end
	end

	// stimulus and end of run
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty list, then a few entries with extreme values
		add_req(pida_pkg::REQ_RD, 0, 32'h0);
		add_req(pida_pkg::REQ_DEL, 0, 32'h0);
		add_req(pida_pkg::REQ_INS, 1, 32'h1234_5678);
		add_req(pida_pkg::REQ_INS, 0, 32'h7fff_ffff);
		add_req(pida_pkg::REQ_INS, 1, 32'h8000_0000);
		add_req(pida_pkg::REQ_INS, 0, 32'hffff_ffff);
		add_req(pida_pkg::REQ_INS, 1, 32'h0000_0000);
		for (int i = 0; i < 4; i++)
			add_req(pida_pkg::REQ_RD, i, 32'h0);
		// reads and inserts beyond the end, unused request type
		add_req(pida_pkg::REQ_RD, 4, 32'h0);
		add_req(pida_pkg::REQ_RD, 127, 32'h0);
		add_req(pida_pkg::REQ_INS, 127, 32'h5555_aaaa);
		add_req(REQ_UNUSED, 0, 32'haaaa_5555);
		// deletes from the middle and the end, one out of range
		add_req(pida_pkg::REQ_DEL, 1, 32'h0);
		add_req(pida_pkg::REQ_DEL, 2, 32'h0);
		add_req(pida_pkg::REQ_DEL, 5, 32'h0);
		add_req(pida_pkg::REQ_INS, 64, 32'h0);
		add_req(pida_pkg::REQ_RD, 0, 32'h0);
		add_req(pida_pkg::REQ_RD, 1, 32'h0);
		add_req(pida_pkg::REQ_DEL, 0, 32'h0);
		add_req(pida_pkg::REQ_DEL, 0, 32'h0);

		// first segment pushes the list towards full
		gap_pct = 15;
		add_random(650, 90);
		wait_drained();
		gap_pct = 82;
		add_random(650, 50);
		wait_drained();
		gap_pct = 0;
		add_random(650, 85);
		wait_drained();

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests: %0d ok (%0d reads), %0d bad position, %0d full",
			n_ok + n_badpos + n_full, n_ok, n_reads, n_badpos, n_full);
		$display("list reached %0d of %0d entries in %0d cycles",
			deepest, pida_pkg::DEPTH, cycle_count);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* positional_insert_delete_array.f */
hdl/pida_pkg.sv
hdl/pida_cell.sv
hdl/positional_insert_delete_array.sv
hdl/pida_checker.sv
bench/tb_positional_insert_delete_array.sv
